[rtl/core/field_extent_run_scanner_defines.svh]
// Assertion macros used by the scanner top level.
`ifndef FIELD_EXTENT_RUN_SCANNER_DEFINES_SVH
`define FIELD_EXTENT_RUN_SCANNER_DEFINES_SVH

// Check a same-cycle implication, sampled on clk and disabled while rst_n is low.
`define FERS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check an implication in the next cycle, sampled on clk and disabled while rst_n is low.
`define FERS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/fers_pkg.sv]
// Shared constants, codes and types of the field extent run scanner.
package fers_pkg;

    // Index range of the scan line
    localparam int INDEX_BITS = 10;
    localparam logic [INDEX_BITS-1:0] IDX_MAX = {INDEX_BITS{1'b1}};
    localparam logic [INDEX_BITS-1:0] EMPTY_LOW =
        (1000 > int'(IDX_MAX)) ? IDX_MAX : INDEX_BITS'(1000);

    // Field widths
    localparam int KIND_W  = 2;
    localparam int POS_W   = 10;
    localparam int STEP_W  = 5;
    localparam int THR_W   = 8;
    localparam int RATIO_W = 4;

    // Segment length saturates at 14 bits
    localparam int LEN_BITS = 14;
    localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_PIXEL = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EOL   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    // Register indexes, taken from paddr[3:2]
    localparam int REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_SAMPLE_STEP   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_RUN_THRESHOLD = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_GAP_THRESHOLD = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_REPLACE_RATIO = 2'd3;

    // Outcome of closing a run
    typedef struct packed {
        logic                  take;
        logic [INDEX_BITS-1:0] low;
        logic [INDEX_BITS-1:0] high;
        logic [LEN_BITS-1:0]   len;
    } seg_t;

endpackage

[rtl/core/fers_segment.sv]
// Segment geometry and extent merge for a closed run.
module fers_segment (
    input  logic [fers_pkg::INDEX_BITS-1:0] run_count,
    input  logic [fers_pkg::INDEX_BITS-1:0] gap_count,
    input  logic [fers_pkg::INDEX_BITS-1:0] pos,
    input  logic [fers_pkg::LEN_BITS-1:0]   last_len,
    input  logic [fers_pkg::INDEX_BITS-1:0] extent_low,
    input  logic [fers_pkg::INDEX_BITS-1:0] extent_high,
    input  logic [fers_pkg::STEP_W-1:0]     sample_step,
    input  logic [fers_pkg::THR_W-1:0]      run_threshold,
    input  logic [fers_pkg::RATIO_W-1:0]    replace_ratio,
    output fers_pkg::seg_t                  seg
);

    localparam int IB = fers_pkg::INDEX_BITS;
    localparam int MW = fers_pkg::INDEX_BITS + fers_pkg::STEP_W + 1;
    localparam int SW = MW + 1;
    localparam int RW = fers_pkg::RATIO_W + fers_pkg::LEN_BITS;

    logic [MW-1:0]                  run_prod;
    logic [MW-1:0]                  gap_prod;
    logic [fers_pkg::LEN_BITS-1:0]  len;
    logic signed [SW-1:0]           end_s;
    logic signed [SW-1:0]           start_s;
    logic signed [SW-1:0]           step_s;
    logic [IB-1:0]                  start_v;
    logic [IB-1:0]                  end_v;
    logic [RW-1:0]                  ratio_prod;
    logic                           replace;

    // Length of the run and distance back over the trailing gap
    assign run_prod = MW'(run_count) * MW'(sample_step);
    assign gap_prod = MW'(gap_count) * MW'(sample_step);
    assign len = (run_prod > MW'(fers_pkg::LEN_MAX)) ? fers_pkg::LEN_MAX
                                                    : run_prod[fers_pkg::LEN_BITS-1:0];

    // End and start of the segment, signed so that underflow shows
    assign end_s   = $signed({1'b0, MW'(pos)}) - $signed({1'b0, gap_prod});
    assign start_s = end_s - $signed({1'b0, MW'(len)});
    assign step_s  = $signed({1'b0, MW'(sample_step)});

    // Snap a start that lies within one step of the line origin to zero; clamp the end to the index range
    always_comb
    begin
        if (start_s < step_s)
        begin
            start_v = '0;
        end
        else
        begin
            start_v = start_s[IB-1:0];
        end
        if (end_s < 0)
        begin
            end_v = '0;
        end
        else if (end_s > $signed({1'b0, MW'(fers_pkg::IDX_MAX)}))
        begin
            end_v = fers_pkg::IDX_MAX;
        end
        else
        begin
            end_v = end_s[IB-1:0];
        end
    end

    // Replace on a markedly longer run, otherwise widen
    assign ratio_prod = RW'(replace_ratio) * RW'(last_len);
    assign replace    = RW'(len) > ratio_prod;

    always_comb
    begin
        seg.take = run_count > IB'(run_threshold);
        seg.len  = len;
        if (replace)
        begin
            seg.low  = start_v;
            seg.high = end_v;
        end
        else
        begin
            seg.low  = (start_v < extent_low)  ? start_v : extent_low;
            seg.high = (end_v   > extent_high) ? end_v   : extent_high;
        end
    end

endmodule

[rtl/core/field_extent_run_scanner.sv]
// Top level of the field extent run scanner: handshakes, state and register port.
//
// Takes one transaction per clock while out_ready is high and returns one result
// per transaction, in order. Each item passes an input register and then a result
// register; a result held by out_ready keeps the item behind it in the input register
// and drops in_ready. The state update runs the run/gap counters, the two step
// multiplies and the extent merge combinationally between the two registers. Write
// the registers only while no item is in flight. Register map (byte address):
// 0 sample_step, 4 run_threshold, 8 gap_threshold, 12 replace_ratio.
module field_extent_run_scanner (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [3:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [fers_pkg::KIND_W-1:0]       kind,
    input  logic                              is_field_color,
    input  logic [fers_pkg::POS_W-1:0]        position,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              segment_accepted,
    output logic [fers_pkg::POS_W-1:0]        extent_min,
    output logic [fers_pkg::POS_W-1:0]        extent_max,
    output logic                              field_seen
);

    `include "field_extent_run_scanner_defines.svh"

    localparam int IB = fers_pkg::INDEX_BITS;
    localparam int PW = (fers_pkg::POS_W > IB) ? fers_pkg::POS_W : IB;

    function automatic logic [IB-1:0] sat_inc(input logic [IB-1:0] v);
        return (v == fers_pkg::IDX_MAX) ? fers_pkg::IDX_MAX : v + 1'b1;
    endfunction

    // Configuration registers
    logic [fers_pkg::STEP_W-1:0]  sample_step_reg;
    logic [fers_pkg::THR_W-1:0]   run_threshold_reg;
    logic [fers_pkg::THR_W-1:0]   gap_threshold_reg;
    logic [fers_pkg::RATIO_W-1:0] replace_ratio_reg;
    logic                         cfg_write;

    // Input register
    logic                         s1_valid_reg;
    logic [fers_pkg::KIND_W-1:0]  kind_reg;
    logic                         field_reg;
    logic [fers_pkg::POS_W-1:0]   pos_reg;
    logic                         s1_fire;

    // Scanner state
    logic [IB-1:0]                run_count_reg, run_count_next;
    logic [IB-1:0]                gap_count_reg, gap_count_next;
    logic [fers_pkg::LEN_BITS-1:0] last_len_reg, last_len_next;
    logic [IB-1:0]                extent_low_reg, extent_low_next;
    logic [IB-1:0]                extent_high_reg, extent_high_next;
    logic                         seen_flag_reg, seen_flag_next;
    logic                         accepted_next;

    // Result register
    logic                         out_valid_reg;
    logic                         accepted_reg;
    logic [fers_pkg::POS_W-1:0]   ext_min_reg;
    logic [fers_pkg::POS_W-1:0]   ext_max_reg;
    logic                         seen_out_reg;

    // Combinational helpers
    logic [PW-1:0]                pos_ext;
    logic [IB-1:0]                pos_sat;
    logic [IB-1:0]                gap_inc;
    logic [IB-1:0]                gap_close;
    logic [IB:0]                  bridged_sum;
    logic [IB-1:0]                run_bridged;
    logic                         close_run;
    fers_pkg::seg_t               seg;

    // Register port
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_step_reg   <= fers_pkg::STEP_W'(4);
            run_threshold_reg <= fers_pkg::THR_W'(2);
            gap_threshold_reg <= fers_pkg::THR_W'(1);
            replace_ratio_reg <= fers_pkg::RATIO_W'(2);
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                fers_pkg::REG_SAMPLE_STEP:
                    sample_step_reg   <= pwdata[fers_pkg::STEP_W-1:0];
                fers_pkg::REG_RUN_THRESHOLD:
                    run_threshold_reg <= pwdata[fers_pkg::THR_W-1:0];
                fers_pkg::REG_GAP_THRESHOLD:
                    gap_threshold_reg <= pwdata[fers_pkg::THR_W-1:0];
                fers_pkg::REG_REPLACE_RATIO:
                    replace_ratio_reg <= pwdata[fers_pkg::RATIO_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            fers_pkg::REG_SAMPLE_STEP:   prdata = 32'(sample_step_reg);
            fers_pkg::REG_RUN_THRESHOLD: prdata = 32'(run_threshold_reg);
            fers_pkg::REG_GAP_THRESHOLD: prdata = 32'(gap_threshold_reg);
            fers_pkg::REG_REPLACE_RATIO: prdata = 32'(replace_ratio_reg);
            default:                     prdata = '0;
        endcase
    end

    // Handshake: advance the input stage whenever the result register can take it
    assign s1_fire  = s1_valid_reg & (~out_valid_reg | out_ready);
    assign in_ready = ~s1_valid_reg | s1_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s1_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Capture the transaction payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            kind_reg  <= kind;
            field_reg <= is_field_color;
            pos_reg   <= position;
        end
    end

    // Clamp the position to the index range
    assign pos_ext = PW'(pos_reg);
    assign pos_sat = (pos_ext > PW'(fers_pkg::IDX_MAX)) ? fers_pkg::IDX_MAX : pos_ext[IB-1:0];

    // Run and gap counters
    assign gap_inc     = sat_inc(gap_count_reg);
    assign bridged_sum = {1'b0, run_count_reg} + {1'b0, gap_count_reg};

    always_comb
    begin
        if (run_count_reg > IB'(run_threshold_reg) && gap_count_reg <= IB'(gap_threshold_reg))
        begin
            run_bridged = bridged_sum[IB] ? fers_pkg::IDX_MAX : bridged_sum[IB-1:0];
        end
        else
        begin
            run_bridged = run_count_reg;
        end
    end

    assign gap_close = (kind_reg == fers_pkg::KIND_PIXEL) ? gap_inc : gap_count_reg;

    fers_segment u_segment (
        .run_count     (run_count_reg),
        .gap_count     (gap_close),
        .pos           (pos_sat),
        .last_len      (last_len_reg),
        .extent_low    (extent_low_reg),
        .extent_high   (extent_high_reg),
        .sample_step   (sample_step_reg),
        .run_threshold (run_threshold_reg),
        .replace_ratio (replace_ratio_reg),
        .seg           (seg)
    );

    // Next state for the item in the input stage
    always_comb
    begin
        run_count_next   = run_count_reg;
        gap_count_next   = gap_count_reg;
        last_len_next    = last_len_reg;
        extent_low_next  = extent_low_reg;
        extent_high_next = extent_high_reg;
        seen_flag_next   = seen_flag_reg;
        close_run        = 1'b0;
        accepted_next    = 1'b0;
        case (kind_reg)
            fers_pkg::KIND_PIXEL:
            begin
                if (field_reg)
                begin
                    run_count_next = sat_inc(run_bridged);
                    gap_count_next = '0;
                end
                else if (gap_inc > IB'(gap_threshold_reg))
                begin
                    close_run      = 1'b1;
                    run_count_next = '0;
                    gap_count_next = '0;
                end
                else
                begin
                    gap_count_next = gap_inc;
                end
            end
            fers_pkg::KIND_EOL:
            begin
                close_run      = 1'b1;
                run_count_next = '0;
                gap_count_next = '0;
            end
            fers_pkg::KIND_CLEAR:
            begin
                run_count_next   = '0;
                gap_count_next   = '0;
                last_len_next    = '0;
                extent_low_next  = fers_pkg::EMPTY_LOW;
                extent_high_next = '0;
                seen_flag_next   = 1'b0;
            end
            default: ;
        endcase
        // Merge a closed run that forms a segment
        if (close_run && seg.take)
        begin
            extent_low_next  = seg.low;
            extent_high_next = seg.high;
            last_len_next    = seg.len;
            seen_flag_next   = 1'b1;
            accepted_next    = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_count_reg   <= '0;
            gap_count_reg   <= '0;
            last_len_reg    <= '0;
            extent_low_reg  <= fers_pkg::EMPTY_LOW;
            extent_high_reg <= '0;
            seen_flag_reg   <= 1'b0;
        end
        else if (s1_fire)
        begin
            run_count_reg   <= run_count_next;
            gap_count_reg   <= gap_count_next;
            last_len_reg    <= last_len_next;
            extent_low_reg  <= extent_low_next;
            extent_high_reg <= extent_high_next;
            seen_flag_reg   <= seen_flag_next;
        end
    end

    // Load the result register
    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            accepted_reg <= accepted_next;
            ext_min_reg  <= fers_pkg::POS_W'(extent_low_next);
            ext_max_reg  <= fers_pkg::POS_W'(extent_high_next);
            seen_out_reg <= seen_flag_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign segment_accepted = accepted_reg;
    assign extent_min       = ext_min_reg;
    assign extent_max       = ext_max_reg;
    assign field_seen       = seen_out_reg;

    // Checks on the state update and result path
    `FERS_ASSERT_IMP(a_accept_implies_seen, out_valid_reg && accepted_reg, seen_out_reg, "segment accepted without field seen")
    `FERS_ASSERT_IMP(a_extent_ordered, seen_flag_reg, extent_low_reg <= extent_high_reg, "extent start lies beyond its end")
    `FERS_ASSERT_NXT(a_clear_empties, s1_fire && kind_reg == fers_pkg::KIND_CLEAR, extent_low_reg == fers_pkg::EMPTY_LOW && !seen_flag_reg && run_count_reg == '0, "clear left state behind")
    `FERS_ASSERT_NXT(a_fire_gives_result, s1_fire, out_valid_reg, "advanced transaction produced no result")

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for the field extent run scanner.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // Reserved item kind
    localparam logic [fers_pkg::KIND_W-1:0] KIND_RESERVED = 2'd3;

    localparam int IDLE_NONE  = 0;
    localparam int IDLE_FULL  = 1;
    localparam int IDLE_SOME  = 2;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 500000;
    localparam int DIRECTED_ROWS = 25;

    typedef struct packed {
        logic                            accepted;
        logic [fers_pkg::INDEX_BITS-1:0] lo;
        logic [fers_pkg::INDEX_BITS-1:0] hi;
        logic                            seen;
    } extent_report_t;

    typedef struct packed {
        logic [fers_pkg::KIND_W-1:0] k;
        logic                        fld;
        logic [fers_pkg::POS_W-1:0]  p;
        bit                          typed;
        extent_report_t              val;
    } stim_row_t;

    localparam extent_report_t EMPTY_REPORT = '{1'b0, fers_pkg::EMPTY_LOW, '0, 1'b0};
    localparam extent_report_t NO_TYPED = '0;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [3:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [fers_pkg::KIND_W-1:0] kind = fers_pkg::KIND_PIXEL;
    logic is_field_color = 1'b0;
    logic [fers_pkg::POS_W-1:0] position = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic segment_accepted;
    logic [fers_pkg::POS_W-1:0] extent_min;
    logic [fers_pkg::POS_W-1:0] extent_max;
    logic field_seen;

    // Typed-in expectation travelling with the item on the input side
    bit row_typed = 1'b0;
    extent_report_t row_typed_val = '0;

    // Predictor configuration and state
    logic [fers_pkg::STEP_W-1:0]     cfg_step = 5'd4;
    logic [fers_pkg::THR_W-1:0]      cfg_run_thr = 8'd2;
    logic [fers_pkg::THR_W-1:0]      cfg_gap_thr = 8'd1;
    logic [fers_pkg::RATIO_W-1:0]    cfg_ratio = 4'd2;
    logic [fers_pkg::INDEX_BITS-1:0] run_cnt;
    logic [fers_pkg::INDEX_BITS-1:0] gap_cnt;
    logic [fers_pkg::LEN_BITS-1:0]   prev_len;
    logic [fers_pkg::INDEX_BITS-1:0] ext_lo;
    logic [fers_pkg::INDEX_BITS-1:0] ext_hi;
    logic                            ever_seen;

    extent_report_t pending_extents[$];
    int mismatch_count = 0;
    int cycle_count = 0;
    int tx_idle_mode = IDLE_FULL;
    int rx_idle_mode = IDLE_FULL;
    bit rx_hold_req = 1'b0;

    // Directed rows, run under the reset register values
    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{KIND_RESERVED,        1'b1, 10'd1023, 1'b1, EMPTY_REPORT},
        '{fers_pkg::KIND_EOL,   1'b0, 10'd0,    1'b1, EMPTY_REPORT},
        '{fers_pkg::KIND_PIXEL, 1'b0, 10'd0,    1'b0, NO_TYPED},
        '{fers_pkg::KIND_PIXEL, 1'b1, 10'd1020, 1'b0, NO_TYPED},
        '{fers_pkg::KIND_PIXEL, 1'b1, 10'd1021, 1'b0, NO_TYPED},
        '{fers_pkg::KIND_PIXEL, 1'b1, 10'd1022, 1'b0, NO_TYPED},
        '{fers_pkg::KIND_PIXEL, 1'b1, 10'd1023, 1'b0, NO_TYPED},
        '{fers_pkg::KIND_EOL,   1'b0, 10'd1023, 1'b1, '{1'b1, 10'd1007, 10'd1023, 1'b1}},
        '{fers_pkg::KIND_CLEAR, 1'b1, 10'd512,  1'b1, EMPTY_REPORT},
        '{fers_pkg::KIND_PIXEL, 1'b1, 10'd4,    1'b0, NO_TYPED},
        '{fers_pkg::KIND_PIXEL, 1'b1, 10'd8,    1'b0, NO_TYPED},
        '{fers_pkg::KIND_PIXEL, 1'b1, 10'd12,   1'b0, NO_TYPED},
        '{fers_pkg::KIND_PIXEL, 1'b0, 10'd16,   1'b0, NO_TYPED},
        '{fers_pkg::KIND_PIXEL, 1'b1, 10'd20,   1'b0, NO_TYPED},
        '{fers_pkg::KIND_PIXEL, 1'b0, 10'd24,   1'b0, NO_TYPED},
        '{fers_pkg::KIND_PIXEL, 1'b0, 10'd28,   1'b0, NO_TYPED},
        '{fers_pkg::KIND_PIXEL, 1'b1, 10'd32,   1'b0, NO_TYPED},
        '{fers_pkg::KIND_PIXEL, 1'b1, 10'd36,   1'b0, NO_TYPED},
        '{fers_pkg::KIND_EOL,   1'b1, 10'd40,   1'b0, NO_TYPED},
        '{fers_pkg::KIND_PIXEL, 1'b1, 10'd682,  1'b0, NO_TYPED},
        '{fers_pkg::KIND_PIXEL, 1'b1, 10'd341,  1'b0, NO_TYPED},
        '{fers_pkg::KIND_PIXEL, 1'b1, 10'd1023, 1'b0, NO_TYPED},
        '{fers_pkg::KIND_EOL,   1'b0, 10'd341,  1'b0, NO_TYPED},
        '{KIND_RESERVED,        1'b0, 10'd0,    1'b0, NO_TYPED},
        '{fers_pkg::KIND_CLEAR, 1'b0, 10'd1023, 1'b1, EMPTY_REPORT}
    };

    field_extent_run_scanner u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .kind             (kind),
        .is_field_color   (is_field_color),
        .position         (position),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .segment_accepted (segment_accepted),
        .extent_min       (extent_min),
        .extent_max       (extent_max),
        .field_seen       (field_seen)
    );

    // Clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Give up on a hung run
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles", cycle_count);
        $display("testbench failed");
        $finish;
    end

    // Predictor: wipe the scan state back to an empty extent
    function automatic void clear_scan_state();
        run_cnt = '0;
        gap_cnt = '0;
        prev_len = '0;
        ext_lo = fers_pkg::EMPTY_LOW;
        ext_hi = '0;
        ever_seen = 1'b0;
    endfunction

    // Predictor: close the current run at pos, return 1 when a segment is taken
    function automatic bit close_field_run(int pos);
        int step;
        int len;
        int stop;
        int start;
        step = int'(cfg_step);
        if (int'(run_cnt) <= int'(cfg_run_thr))
            return 1'b0;
        len = int'(run_cnt) * step;
        if (len > int'(fers_pkg::LEN_MAX))
            len = int'(fers_pkg::LEN_MAX);
        stop = pos - int'(gap_cnt) * step;
        start = stop - len;
        if (start < step || start < 0)
            start = 0;
        if (stop < 0)
            stop = 0;
        if (stop > int'(fers_pkg::IDX_MAX))
            stop = int'(fers_pkg::IDX_MAX);
        if (len > int'(cfg_ratio) * int'(prev_len))
        begin
            ext_lo = fers_pkg::INDEX_BITS'(start);
            ext_hi = fers_pkg::INDEX_BITS'(stop);
        end
        else
        begin
            if (start < int'(ext_lo))
                ext_lo = fers_pkg::INDEX_BITS'(start);
            if (stop > int'(ext_hi))
                ext_hi = fers_pkg::INDEX_BITS'(stop);
        end
        prev_len = fers_pkg::LEN_BITS'(len);
        ever_seen = 1'b1;
        return 1'b1;
    endfunction

    // Predictor: advance the scan state by one transaction
    function automatic extent_report_t predict_scan(logic [fers_pkg::KIND_W-1:0] k,
                                                    logic fld,
                                                    logic [fers_pkg::POS_W-1:0] p);
        extent_report_t r;
        bit took;
        int merged;
        took = 1'b0;
        case (k)
            fers_pkg::KIND_PIXEL:
            begin
                if (fld)
                begin
                    // bridge a short gap into a run that is already long enough
                    if (run_cnt > cfg_run_thr && gap_cnt <= cfg_gap_thr)
                    begin
                        merged = int'(run_cnt) + int'(gap_cnt);
                        run_cnt = (merged > int'(fers_pkg::IDX_MAX)) ?
                                  fers_pkg::IDX_MAX : fers_pkg::INDEX_BITS'(merged);
                    end
                    run_cnt = (run_cnt == fers_pkg::IDX_MAX) ?
                              fers_pkg::IDX_MAX : run_cnt + 1'b1;
                    gap_cnt = '0;
                end
                else
                begin
                    gap_cnt = (gap_cnt == fers_pkg::IDX_MAX) ?
                              fers_pkg::IDX_MAX : gap_cnt + 1'b1;
                    if (gap_cnt > cfg_gap_thr)
                    begin
                        took = close_field_run(int'(p));
                        run_cnt = '0;
                        gap_cnt = '0;
                    end
                end
            end
            fers_pkg::KIND_EOL:
            begin
                took = close_field_run(int'(p));
                run_cnt = '0;
                gap_cnt = '0;
            end
            fers_pkg::KIND_CLEAR:
            begin
                clear_scan_state();
            end
            default:
            begin
            end
        endcase
        r.accepted = took;
        r.lo = ext_lo;
        r.hi = ext_hi;
        r.seen = ever_seen;
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t ERROR %s: got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // Predict on each input transaction, check each output transaction
    always @(posedge clk)
    begin
        extent_report_t want;
        if (rst_n && in_valid && in_ready)
        begin
            want = predict_scan(kind, is_field_color, position);
            if (row_typed)
                want = row_typed_val;
            pending_extents.insert(pending_extents.size(), want);
        end
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_extents.size() == 0)
            begin
                report_mismatch("result with nothing pending", 1, 0);
            end
            else
            begin
                want = pending_extents.pop_front();
                if (segment_accepted !== want.accepted)
                    report_mismatch("segment_accepted", segment_accepted, want.accepted);
                if (extent_min !== want.lo)
                    report_mismatch("extent_min", extent_min, want.lo);
                if (extent_max !== want.hi)
                    report_mismatch("extent_max", extent_max, want.hi);
                if (field_seen !== want.seen)
                    report_mismatch("field_seen", field_seen, want.seen);
            end
        end
    end

    function automatic int draw_wait(int mode);
        case (mode)
            IDLE_NONE: return 0;
            IDLE_FULL: return $urandom_range(0, 18);
            default:   return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
        endcase
    endfunction

    // Receiver: random stalls, plus one long hold-off on request
    initial
    begin
        int w;
        forever
        begin
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
            end
            w = draw_wait(rx_idle_mode);
            if (w > 0)
            begin
                out_ready <= 1'b0;
                repeat (w) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!out_valid);
        end
    end

    // Offer one transaction after a random gap and hold it until taken
    task automatic send_item(logic [fers_pkg::KIND_W-1:0] k, logic fld,
                             logic [fers_pkg::POS_W-1:0] p,
                             bit typed = 1'b0, extent_report_t typed_val = '0);
        int w;
        w = draw_wait(tx_idle_mode);
        if (w > 0)
        begin
            in_valid <= 1'b0;
            repeat (w) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        is_field_color <= fld;
        position <= p;
        row_typed <= typed;
        row_typed_val <= typed_val;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
    endtask

    task automatic send_run(logic fld, int count, logic [fers_pkg::POS_W-1:0] p);
        repeat (count) send_item(fers_pkg::KIND_PIXEL, fld, p);
    endtask

    // Drop valid and wait until every result is back and the pipe has drained
    task automatic settle_scanner();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_extents.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [fers_pkg::REG_IDX_W-1:0] idx, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            fers_pkg::REG_SAMPLE_STEP:   cfg_step = value[fers_pkg::STEP_W-1:0];
            fers_pkg::REG_RUN_THRESHOLD: cfg_run_thr = value[fers_pkg::THR_W-1:0];
            fers_pkg::REG_GAP_THRESHOLD: cfg_gap_thr = value[fers_pkg::THR_W-1:0];
            fers_pkg::REG_REPLACE_RATIO: cfg_ratio = value[fers_pkg::RATIO_W-1:0];
            default:                     ;
        endcase
        @(posedge clk);
    endtask

    task automatic program_scanner(int step, int run_thr, int gap_thr, int ratio);
        settle_scanner();
        write_reg(fers_pkg::REG_SAMPLE_STEP, step);
        write_reg(fers_pkg::REG_RUN_THRESHOLD, run_thr);
        write_reg(fers_pkg::REG_GAP_THRESHOLD, gap_thr);
        write_reg(fers_pkg::REG_REPLACE_RATIO, ratio);
    endtask

    // Send scan lines of field runs and gaps sized around the thresholds,
    // with stray transactions and missing line ends mixed in
    task automatic send_random_lines(int count);
        int sent;
        int run_len;
        int gap_len;
        int pos;
        sent = 0;
        while (sent < count)
        begin
            pos = $urandom_range(0, 200);
            repeat ($urandom_range(1, 4))
            begin
                run_len = $urandom_range(0, int'(cfg_run_thr) + 6);
                gap_len = $urandom_range(0, int'(cfg_gap_thr) + 2);
                for (int i = 0; i < run_len + gap_len; i++)
                begin
                    if ($urandom_range(0, 15) == 0)
                        send_item(fers_pkg::KIND_W'($urandom_range(0, 3)),
                                  1'($urandom_range(0, 1)),
                                  fers_pkg::POS_W'($urandom_range(0, 1023)));
                    else
                        send_item(fers_pkg::KIND_PIXEL, i < run_len, fers_pkg::POS_W'(pos));
                    pos = (pos + int'(cfg_step) > int'(fers_pkg::IDX_MAX)) ?
                          int'(fers_pkg::IDX_MAX) : pos + int'(cfg_step);
                end
                sent += run_len + gap_len;
            end
            // close the line, mostly at the current position
            if ($urandom_range(0, 7) != 0)
            begin
                if ($urandom_range(0, 3) == 0)
                    send_item(fers_pkg::KIND_EOL, 1'($urandom_range(0, 1)),
                              fers_pkg::POS_W'($urandom_range(0, 1023)));
                else
                    send_item(fers_pkg::KIND_EOL, 1'($urandom_range(0, 1)),
                              fers_pkg::POS_W'(pos));
                sent++;
            end
        end
    endtask

    // Stimulus
    initial
    begin
        clear_scan_state();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows under the reset register values
        tx_idle_mode = IDLE_FULL;
        rx_idle_mode = IDLE_FULL;
        foreach (directed_rows[i])
            send_item(directed_rows[i].k, directed_rows[i].fld, directed_rows[i].p,
                      directed_rows[i].typed, directed_rows[i].val);

        // unit step, zero thresholds, zero ratio
        program_scanner(1, 0, 0, 0);
        send_random_lines(70);

        // zero step, no idling on the sender
        tx_idle_mode = IDLE_NONE;
        rx_idle_mode = IDLE_SOME;
        program_scanner(0, 3, 2, 1);
        send_random_lines(50);

        // out of range step and largest gap threshold: bridge a long gap
        // into the run and close it with the end far behind the limit
        tx_idle_mode = IDLE_SOME;
        rx_idle_mode = IDLE_NONE;
        program_scanner(31, 40, 255, 15);
        send_run(1'b1, 45, 10'd100);
        send_run(1'b0, 30, 10'd600);
        send_run(1'b1, 30, fers_pkg::IDX_MAX);
        send_run(1'b0, 10, fers_pkg::IDX_MAX);
        send_item(fers_pkg::KIND_EOL, 1'b0, fers_pkg::IDX_MAX);

        // largest in-range step and ratio
        tx_idle_mode = IDLE_SOME;
        rx_idle_mode = IDLE_FULL;
        program_scanner(16, 12, 6, 15);
        send_random_lines(70);

        // random settings; the middle phase holds off the receiver
        for (int ph = 0; ph < 3; ph++)
        begin
            program_scanner($urandom_range(1, 16), $urandom_range(0, 6),
                            $urandom_range(0, 4), $urandom_range(0, 15));
            tx_idle_mode = $urandom_range(0, 2);
            rx_idle_mode = $urandom_range(0, 2);
            if (ph == 1)
            begin
                tx_idle_mode = IDLE_NONE;
                rx_hold_req = 1'b1;
            end
            send_random_lines(70);
        end

        // back to the reset values
        tx_idle_mode = IDLE_FULL;
        rx_idle_mode = IDLE_SOME;
        program_scanner(4, 2, 1, 2);
        send_random_lines(70);

        settle_scanner();
        if (mismatch_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
